FILE: design/lfrr_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the lagged Fibonacci range generator.
package lfrr_pkg;

  localparam int DATA_BITS      = 32;
  localparam int SPAN_BITS      = DATA_BITS + 1;
  localparam int SEED_BITS      = 30;
  localparam int WORD_BITS_DEF  = 30;
  localparam int OUT_SHIFT_DEF  = 6;
  localparam int QUEUE_DEPTH    = 2;

  localparam int TABLE_LEN      = 55;
  localparam int LAG_SHORT      = 24;
  localparam int PTR_BITS       = $clog2(TABLE_LEN);

  localparam int PCT_BITS       = 7;
  localparam int PCT_MAX        = 99;

  typedef logic [PTR_BITS-1:0] ptr_t;

  localparam ptr_t LAST_IDX     = ptr_t'(TABLE_LEN - 1);
  localparam ptr_t SHORT_START  = ptr_t'(TABLE_LEN - LAG_SHORT);

  localparam logic [1:0] OP_RAW    = 2'd0;
  localparam logic [1:0] OP_RANGE  = 2'd1;
  localparam logic [1:0] OP_PCT    = 2'd2;
  localparam logic [1:0] OP_RESEED = 2'd3;

  typedef enum logic [2:0] {
    KIND_RAW,
    KIND_RANGE,
    KIND_PCT,
    KIND_RESEED,
    KIND_CONST
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [DATA_BITS-1:0]  low;
    logic [SPAN_BITS-1:0]  span;
    logic [DATA_BITS-1:0]  mask;
  } req_t;

  function automatic ptr_t ptr_inc(input ptr_t p);
    ptr_inc = (p == LAST_IDX) ? '0 : ptr_t'(p + 1'b1);
  endfunction

endpackage

FILE: design/lagged_fibonacci_random_ranges.sv
`timescale 1ns / 1ps
// Top level: seed register, front end, request queue and draw sequencer.
//
//   channel  direction  handshake              payload
//   in       request    in_valid / in_ready    opcode, range_low, range_high
//   out      result     out_valid / out_ready  value
//   cfg      write      cfg_valid / cfg_ready  cfg_data (seed)
//
// A raw draw in the sequencer is a registered table read, then an add and write back.
// A rejected draw repeats with the next read; a one-value range is answered from idle;
// a reseed sweeps all 55 entries, then returns 0. After reset the table is filled from
// the seed, in_ready held low. Front end and queue are each registered; the 2-entry queue
// lets the front keep taking requests while the sequencer or result register is stalled.
module lagged_fibonacci_random_ranges #(
  parameter int WORD_BITS    = lfrr_pkg::WORD_BITS_DEF,
  parameter int OUTPUT_SHIFT = lfrr_pkg::OUT_SHIFT_DEF,
  parameter int QUEUE_DEPTH  = lfrr_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     opcode,
  input  logic signed [31:0]             range_low,
  input  logic signed [31:0]             range_high,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [31:0]             value,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lfrr_pkg::SEED_BITS-1:0] cfg_data
);
  import lfrr_pkg::*;

  logic [SEED_BITS-1:0] seed_value;
  logic                 init_busy;
  req_t                 push_req;
  logic                 push_valid;
  logic                 push_ready;
  req_t                 pop_req;
  logic                 pop_valid;
  logic                 pop_ready;
  logic [DATA_BITS-1:0] value_raw;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_value <= '0;
    end else if (cfg_valid && cfg_ready) begin
      seed_value <= cfg_data;
    end
  end

  lfrr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .hold       (init_busy),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .range_low  (range_low),
    .range_high (range_high),
    .push_req   (push_req),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  lfrr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_req   (push_req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_req    (pop_req),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  lfrr_back #(
    .WORD_BITS    (WORD_BITS),
    .OUTPUT_SHIFT (OUTPUT_SHIFT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .req         (pop_req),
    .req_valid   (pop_valid),
    .req_ready   (pop_ready),
    .seed_value  (seed_value),
    .init_busy   (init_busy),
    .value_valid (out_valid),
    .value_ready (out_ready),
    .value       (value_raw)
  );

  assign value = value_raw;

endmodule

FILE: design/lfrr_ram.sv
`timescale 1ns / 1ps
// Generic RAM: one write port, two registered read ports.
module lfrr_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 55
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: design/lfrr_front.sv
`timescale 1ns / 1ps
// Front end: takes requests, works out span and mask, classifies them.
module lfrr_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  hold,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            opcode,
  input  logic signed [31:0]    range_low,
  input  logic signed [31:0]    range_high,
  output lfrr_pkg::req_t        push_req,
  output logic                  push_valid,
  input  logic                  push_ready
);
  import lfrr_pkg::*;

  logic                  held;
  logic [1:0]            op_q;
  logic [DATA_BITS-1:0]  low_q;
  logic [DATA_BITS-1:0]  high_q;

  logic [DATA_BITS:0]    diff;
  logic                  flat;
  logic [DATA_BITS-1:0]  mask;

  // fill every bit below the top set bit
  function automatic logic [DATA_BITS-1:0] smear(input logic [DATA_BITS-1:0] v);
    logic [DATA_BITS-1:0] m;
    m = v;
    for (int sh = 1; sh < DATA_BITS; sh = sh * 2) begin
      m = m | (m >> sh);
    end
    smear = m;
  endfunction

  always_comb begin
    diff = {high_q[DATA_BITS-1], high_q} - {low_q[DATA_BITS-1], low_q};
    flat = diff[DATA_BITS] || (diff == '0);
    mask = smear(diff[DATA_BITS-1:0]);

    push_req.low  = low_q;
    push_req.span = {1'b0, diff[DATA_BITS-1:0]} + SPAN_BITS'(1);
    push_req.mask = mask;
    case (op_q)
      OP_RAW:    push_req.kind = KIND_RAW;
      OP_RANGE:  push_req.kind = flat ? KIND_CONST : KIND_RANGE;
      OP_PCT:    push_req.kind = KIND_PCT;
      OP_RESEED: push_req.kind = KIND_RESEED;
      default:   push_req.kind = KIND_RAW;
    endcase
  end

  assign push_valid = held;
  assign in_ready   = !hold && (!held || push_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (push_ready) begin
      held <= 1'b0;
    end
    if (in_valid && in_ready) begin
      op_q   <= opcode;
      low_q  <= range_low;
      high_q <= range_high;
    end
  end

endmodule

FILE: design/lfrr_queue.sv
`timescale 1ns / 1ps
// Short request queue between the front end and the draw sequencer.
module lfrr_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  lfrr_pkg::req_t push_req,
  input  logic           push_valid,
  output logic           push_ready,
  output lfrr_pkg::req_t pop_req,
  output logic           pop_valid,
  input  logic           pop_ready
);
  import lfrr_pkg::*;

  localparam int IDX_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  req_t                entries [DEPTH];
  logic [IDX_BITS-1:0] wr_ptr;
  logic [IDX_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count != CNT_BITS'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_req    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == IDX_BITS'(DEPTH - 1)) ? '0 : IDX_BITS'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == IDX_BITS'(DEPTH - 1)) ? '0 : IDX_BITS'(rd_ptr + 1'b1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= CNT_BITS'(count + 1'b1);
        2'b01:   count <= CNT_BITS'(count - 1'b1);
        default: count <= count;
      endcase
    end
    if (do_push) begin
      entries[wr_ptr] <= push_req;
    end
  end

endmodule

FILE: design/lfrr_back.sv
`timescale 1ns / 1ps
// Draw sequencer: lag table updates, rejection loop, reseed sweep, result register.
module lfrr_back #(
  parameter int WORD_BITS    = lfrr_pkg::WORD_BITS_DEF,
  parameter int OUTPUT_SHIFT = lfrr_pkg::OUT_SHIFT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  lfrr_pkg::req_t                 req,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  logic [lfrr_pkg::SEED_BITS-1:0] seed_value,
  output logic                           init_busy,
  output logic                           value_valid,
  input  logic                           value_ready,
  output logic [lfrr_pkg::DATA_BITS-1:0] value
);
  import lfrr_pkg::*;

  localparam int RAW_BITS = WORD_BITS - OUTPUT_SHIFT;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAW,
    ST_FILL,
    ST_EMIT
  } state_t;

  state_t                state;
  req_t                  cur;
  ptr_t                  long_ptr;
  ptr_t                  short_ptr;
  ptr_t                  long_next;
  ptr_t                  short_next;
  ptr_t                  fill_idx;
  logic                  fill_ack;
  logic [WORD_BITS-1:0]  prev1;
  logic [WORD_BITS-1:0]  prev2;
  logic [DATA_BITS-1:0]  res;
  logic                  value_valid_next;

  logic                  we;
  ptr_t                  waddr;
  logic [WORD_BITS-1:0]  wdata;
  logic [WORD_BITS-1:0]  rdata_a;
  logic [WORD_BITS-1:0]  rdata_b;

  logic                  can_emit;
  logic [WORD_BITS-1:0]  sum;
  logic [RAW_BITS-1:0]   raw;
  logic [SPAN_BITS-1:0]  raw_wide;
  logic [DATA_BITS-1:0]  num;
  logic [PCT_BITS-1:0]   pct;
  logic                  draw_ok;
  logic [DATA_BITS-1:0]  draw_res;
  logic [WORD_BITS-1:0]  fill_word;

  lfrr_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (TABLE_LEN)
  ) u_table (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (long_next),
    .raddr_b (short_next),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_comb begin
    can_emit = !value_valid || value_ready;
    sum      = rdata_a + rdata_b;
    raw      = sum[WORD_BITS-1:OUTPUT_SHIFT];
    raw_wide = SPAN_BITS'(raw);
    num      = raw_wide[DATA_BITS-1:0] & cur.mask;
    pct      = raw[PCT_BITS-1:0];

    case (cur.kind)
      KIND_RANGE: begin
        draw_ok  = ({1'b0, num} < cur.span);
        draw_res = cur.low + num;
      end
      KIND_PCT: begin
        draw_ok  = (pct <= PCT_BITS'(PCT_MAX));
        draw_res = DATA_BITS'(pct) + DATA_BITS'(1);
      end
      default: begin
        draw_ok  = 1'b1;
        draw_res = raw_wide[DATA_BITS-1:0];
      end
    endcase

    if (fill_idx == '0) begin
      fill_word = WORD_BITS'(seed_value);
    end else if (fill_idx == ptr_t'(1)) begin
      fill_word = WORD_BITS'(1);
    end else begin
      fill_word = prev1 + prev2;
    end

    we               = 1'b0;
    waddr            = long_ptr;
    wdata            = sum;
    long_next        = long_ptr;
    short_next       = short_ptr;
    req_ready        = 1'b0;
    value_valid_next = value_valid && !value_ready;

    case (state)
      ST_IDLE: begin
        // a constant result needs the output slot at once
        if (req_valid) begin
          req_ready = (req.kind == KIND_CONST) ? can_emit : 1'b1;
        end
        if (req_valid && req_ready && (req.kind == KIND_CONST)) begin
          value_valid_next = 1'b1;
        end
      end
      ST_DRAW: begin
        we         = 1'b1;
        long_next  = ptr_inc(long_ptr);
        short_next = ptr_inc(short_ptr);
        if (draw_ok && can_emit) begin
          value_valid_next = 1'b1;
        end
      end
      ST_FILL: begin
        we         = 1'b1;
        waddr      = fill_idx;
        wdata      = fill_word;
        long_next  = '0;
        short_next = SHORT_START;
      end
      ST_EMIT: begin
        we = 1'b0;
        if (can_emit) begin
          value_valid_next = 1'b1;
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign init_busy = (state == ST_FILL) && !fill_ack;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_FILL;
      fill_idx    <= '0;
      fill_ack    <= 1'b0;
      value_valid <= 1'b0;
      long_ptr    <= '0;
      short_ptr   <= SHORT_START;
    end else begin
      long_ptr    <= long_next;
      short_ptr   <= short_next;
      value_valid <= value_valid_next;
      case (state)
        ST_IDLE: begin
          if (req_valid && req_ready) begin
            cur <= req;
            case (req.kind)
              KIND_CONST: begin
                value <= req.low;
              end
              KIND_RESEED: begin
                state    <= ST_FILL;
                fill_idx <= '0;
                fill_ack <= 1'b1;
              end
              default: begin
                state <= ST_DRAW;
              end
            endcase
          end
        end
        ST_DRAW: begin
          // on reject stay here; the next read is already under way
          if (draw_ok) begin
            if (can_emit) begin
              value <= draw_res;
              state <= ST_IDLE;
            end else begin
              res   <= draw_res;
              state <= ST_EMIT;
            end
          end
        end
        ST_FILL: begin
          prev2    <= prev1;
          prev1    <= fill_word;
          fill_idx <= ptr_inc(fill_idx);
          if (fill_idx == LAST_IDX) begin
            if (fill_ack) begin
              res   <= '0;
              state <= ST_EMIT;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_EMIT: begin
          if (can_emit) begin
            value <= res;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_lag_spacing: assert property (@(posedge clk) disable iff (rst)
    (short_ptr == ptr_t'(long_ptr + SHORT_START)) ||
    (ptr_t'(short_ptr + ptr_t'(LAG_SHORT)) == long_ptr))
    else $error("lag pointers out of step");

  a_fill_no_pop: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL) |-> !req_ready)
    else $error("request taken during table fill");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL) |-> (fill_idx <= LAST_IDX))
    else $error("fill index beyond table");

  a_draw_emit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAW && draw_ok && can_emit) |=> value_valid)
    else $error("accepted draw not presented");

endmodule

FILE: tb/lfrr_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the lagged Fibonacci generator: shadow lag table, expected values and checks.
module lfrr_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [1:0]                     opcode,
  input  logic signed [31:0]             range_low,
  input  logic signed [31:0]             range_high,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic signed [31:0]             value,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [lfrr_pkg::SEED_BITS-1:0] cfg_data,
  output int                             outstanding,
  output int                             mismatches
);
  import lfrr_pkg::*;

  localparam int RAW_BITS = WORD_BITS_DEF - OUT_SHIFT_DEF;

  logic [WORD_BITS_DEF-1:0] lags [TABLE_LEN];
  logic [SEED_BITS-1:0]     seed;
  int                       oldest;
  int                       tap;
  logic signed [31:0]       awaited_values [$];
  int                       fault_count = 0;

  function automatic void refill_lags();
    lags[0] = WORD_BITS_DEF'(seed);
    lags[1] = WORD_BITS_DEF'(1);
    for (int i = 2; i < TABLE_LEN; i++) begin
      lags[i] = lags[i-1] + lags[i-2];
    end
    oldest = 0;
    tap    = SHORT_START;
  endfunction

  // One generator step: add the oldest word to the short-lag word and store it back.
  function automatic logic [RAW_BITS-1:0] advance_lags();
    logic [WORD_BITS_DEF-1:0] sum;
    sum          = lags[oldest] + lags[tap];
    lags[oldest] = sum;
    oldest       = (oldest == TABLE_LEN - 1) ? 0 : oldest + 1;
    tap          = (tap == TABLE_LEN - 1) ? 0 : tap + 1;
    return RAW_BITS'(sum >> OUT_SHIFT_DEF);
  endfunction

  function automatic logic signed [31:0] predict_value(input logic [1:0] op,
                                                       input logic signed [31:0] lo,
                                                       input logic signed [31:0] hi);
    logic signed [31:0]  outcome;
    longint              span;
    longint              bound;
    longint              pick;
    logic [PCT_BITS-1:0] pct;
    outcome = '0;
    case (op)
      OP_RAW: begin
        outcome = 32'(advance_lags());
      end
      OP_RANGE: begin
        span = longint'(hi) - longint'(lo) + 1;
        if (span <= 1) begin
          outcome = lo;
        end else begin
          bound = 2;
          while (bound < span) bound = bound << 1;
          // reject draws that land past the span
          do pick = longint'(advance_lags()) & (bound - 1); while (pick >= span);
          outcome = lo + 32'(pick);
        end
      end
      OP_PCT: begin
        do pct = PCT_BITS'(advance_lags()); while (pct > PCT_MAX);
        outcome = 32'(pct) + 32'd1;
      end
      OP_RESEED: begin
        refill_lags();
        outcome = '0;
      end
      default: begin
        outcome = '0;
      end
    endcase
    return outcome;
  endfunction

  always @(posedge clk) begin : watch
    logic signed [31:0] want;
    if (rst) begin
      seed = '0;
      refill_lags();
      awaited_values.delete();
      fault_count = 0;
      outstanding <= 0;
      mismatches  <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        seed = cfg_data;
      end
      if (in_valid && in_ready) begin
        awaited_values.push_back(predict_value(opcode, range_low, range_high));
      end
      if (out_valid && out_ready) begin
        if (awaited_values.size() == 0) begin
          $display("%0t: unexpected result %0d, no request outstanding", $time, value);
          fault_count++;
        end else begin
          want = awaited_values.pop_front();
          if (value !== want) begin
            $display("%0t: value mismatch, expected %0d, got %0d", $time, want, value);
            fault_count++;
          end
        end
      end
      outstanding <= awaited_values.size();
      mismatches  <= fault_count;
    end
  end

endmodule

FILE: tb/tb_lagged_fibonacci_random_ranges.sv
`timescale 1ns / 1ps
// Testbench top for the lagged Fibonacci generator: clock, reset, stimulus and verdict.
module tb_lagged_fibonacci_random_ranges;
  import lfrr_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int LONG_HOLD   = 400;
  localparam int PHASES      = 5;
  localparam int PHASE_ITEMS = 175;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic [1:0]             opcode;
  logic signed [31:0]     range_low;
  logic signed [31:0]     range_high;
  logic                   out_valid;
  logic                   out_ready;
  logic signed [31:0]     value;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [SEED_BITS-1:0]   cfg_data;

  int outstanding;
  int mismatches;
  int quiet_cycles = 0;
  int src_idle_pct;
  int sink_idle_pct;
  bit long_hold_req;

  always #5 clk = ~clk;

  lagged_fibonacci_random_ranges u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .range_low (range_low),
    .range_high(range_high),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  lfrr_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .range_low  (range_low),
    .range_high (range_high),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .outstanding(outstanding),
    .mismatches (mismatches)
  );

  // Watchdog: give up when no channel has moved for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side back-pressure.
  initial begin : sink
    int  gap;
    bit  held;
    held = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
        gap = $urandom_range(1, 12);
        out_ready <= 1'b0;
        repeat (gap - 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_request(input logic [1:0] op, input logic signed [31:0] lo,
                              input logic signed [31:0] hi);
    int gap;
    if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    range_low  <= lo;
    range_high <= hi;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold the request side and wait for every outstanding result.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_seed(input logic [SEED_BITS-1:0] s);
    cfg_valid <= 1'b1;
    cfg_data  <= s;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic directed_requests();
    send_request(OP_RAW, 32'sd0, 32'sd0);
    send_request(OP_RAW, -32'sd1, -32'sd1);
    send_request(OP_RANGE, 32'sd5, 32'sd5);                      // single value
    send_request(OP_RANGE, 32'sd10, -32'sd10);                   // bounds swapped
    send_request(OP_RANGE, 32'h7FFF_FFFF, 32'h8000_0000);        // most negative span
    send_request(OP_RANGE, 32'h8000_0000, 32'h7FFF_FFFF);        // whole 32-bit span
    send_request(OP_RANGE, 32'h8000_0000, 32'h7FFF_FFFE);
    send_request(OP_RANGE, 32'sd0, 32'sd1);                      // span of two
    send_request(OP_RANGE, -32'sd3, 32'sd3);
    send_request(OP_RANGE, 32'sd0, 32'sd4);                      // heavy rejection
    send_request(OP_RANGE, 32'sd0, 32'h00FF_FFFF);               // exactly the raw width
    send_request(OP_RANGE, 32'sd0, 32'h0100_0000);               // just past the raw width
    send_request(OP_RANGE, 32'h7FFF_FFF0, 32'h7FFF_FFFF);
    send_request(OP_RANGE, 32'h8000_0000, 32'h8000_0002);
    send_request(OP_RANGE, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_request(OP_PCT, $urandom, $urandom);
    send_request(OP_PCT, 32'sd0, 32'sd0);
    send_request(OP_PCT, -32'sd1, -32'sd1);
    send_request(OP_RESEED, $urandom, $urandom);
    send_request(OP_RAW, $urandom, $urandom);
    send_request(OP_RAW, $urandom, $urandom);
    send_request(OP_RANGE, -32'sd100, 32'sd100);
  endtask

  task automatic random_request();
    logic [1:0]         op;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    longint             span;
    int                 pick;
    int                 k;
    pick = $urandom_range(0, 99);
    if (pick < 22) op = OP_RAW;
    else if (pick < 68) op = OP_RANGE;
    else if (pick < 92) op = OP_PCT;
    else op = OP_RESEED;
    lo = $urandom;
    hi = $urandom;
    if (op == OP_RANGE) begin
      case ($urandom_range(0, 5))
        0: span = longint'($urandom_range(1, 300));
        1: begin
          k    = $urandom_range(1, 32);
          span = (longint'(1) << k) + longint'($urandom_range(0, 2)) - 1;
        end
        2: span = longint'(hi) - longint'(lo) + 1;
        3: span = longint'($urandom_range(0, 6)) - 5;
        4: span = (longint'(1) << 24) + longint'($urandom_range(0, 1 << 20)) - (longint'(1) << 19);
        default: begin
          lo   = -$signed(32'($urandom_range(0, 1000)));
          span = longint'($urandom_range(1, 2000));
        end
      endcase
      hi = 32'(longint'(lo) + span - 1);
    end
    send_request(op, lo, hi);
  endtask

  initial begin : stimulus
    logic [SEED_BITS-1:0] phase_seed;
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    opcode        <= OP_RAW;
    range_low     <= '0;
    range_high    <= '0;
    cfg_valid     <= 1'b0;
    cfg_data      <= '0;
    src_idle_pct  = 20;
    sink_idle_pct = 8;
    long_hold_req = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset seed first, then let everything settle
    directed_requests();
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: phase_seed = '1;
        1: phase_seed = '0;
        2: phase_seed = SEED_BITS'(1);
        default: phase_seed = SEED_BITS'($urandom);
      endcase
      case (p)
        0: begin src_idle_pct = 20; sink_idle_pct = 8; end
        1: begin src_idle_pct = 0; sink_idle_pct = 4; long_hold_req = 1'b1; end
        2: begin src_idle_pct = 0; sink_idle_pct = 15; end
        3: begin src_idle_pct = 10; sink_idle_pct = 0; end
        default: begin src_idle_pct = 0; sink_idle_pct = 0; end
      endcase
      write_seed(phase_seed);
      // keep the old table in one phase so the new seed only shows after a random reseed
      if (p != 2) begin
        send_request(OP_RESEED, $urandom, $urandom);
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        random_request();
      end
      drain();
    end

    repeat (64) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/lfrr_pkg.sv
design/lfrr_ram.sv
design/lfrr_front.sv
design/lfrr_queue.sv
design/lfrr_back.sv
design/lagged_fibonacci_random_ranges.sv
tb/lfrr_checker.sv
tb/tb_lagged_fibonacci_random_ranges.sv
